FILE: sv/text_tile_background_pixel_defines.svh
// Assertion helpers shared by the tile fetch modules.
// Each macro expects clk and rst in scope.
`ifndef TEXT_TILE_BACKGROUND_PIXEL_DEFINES_SVH
`define TEXT_TILE_BACKGROUND_PIXEL_DEFINES_SVH

// Same-cycle implication.
`define TTBP_ASSERT_NOW(label, cond_a, cond_c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
    else $error(msg);

// Next-cycle implication.
`define TTBP_ASSERT_NEXT(label, cond_a, cond_c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
    else $error(msg);

`endif

FILE: sv/ttbp_pkg.sv
package ttbp_pkg;

  // Sizes of the video memory and the visible screen
  localparam int VIDEO_HALFWORDS = 32768;
  localparam int SCREEN_COLUMNS  = 240;
  localparam int SCREEN_ROWS     = 160;

  localparam int VADDR_W     = $clog2(VIDEO_HALFWORDS);
  localparam int VIDEO_BYTES = 2 * VIDEO_HALFWORDS;
  localparam int BYTE_ADDR_W = 17;
  localparam int PAL_DEPTH   = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Item operation codes
  localparam logic [1:0] OP_VIDEO_WRITE   = 2'd0;
  localparam logic [1:0] OP_PALETTE_WRITE = 2'd1;
  localparam logic [1:0] OP_FETCH         = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_BASE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_BASE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_COLOUR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_X    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y    = 3'd5;

  typedef struct packed {
    logic [1:0] char_base;
    logic [4:0] map_base;
    logic       wide_colour;
    logic [1:0] map_size;
    logic [8:0] scroll_x;
    logic [8:0] scroll_y;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_VIDEO   = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_FETCH   = 2'd2
  } kind_t;

  // Classified item: addr is the write address, or the map halfword for a fetch
  typedef struct packed {
    kind_t       kind;
    logic [14:0] addr;
    logic [15:0] data;
    logic [2:0]  tpx;
    logic [2:0]  tpy;
    logic        map_oob;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: sv/ttbp_front.sv
module ttbp_front (
  input  ttbp_pkg::cfg_t   cfg,
  input  logic             req_valid,
  input  logic [1:0]       op,
  input  logic [14:0]      write_addr,
  input  logic [15:0]      write_data,
  input  logic [7:0]       pixel_x,
  input  logic [7:0]       pixel_y,
  input  ttbp_pkg::qstat_t qstat,
  output logic             req_stall,
  output logic             push,
  output ttbp_pkg::item_t  push_item
);

  logic        wide;
  logic        tall;
  logic [8:0]  sum_x;
  logic [8:0]  sum_y;
  logic [8:0]  px;
  logic [8:0]  py;
  logic [1:0]  block_off;
  logic [5:0]  map_blk;
  logic [15:0] map_half;
  logic        map_oob;
  logic        on_screen;
  logic        video_ok;
  logic        palette_ok;
  logic        keep;
  ttbp_pkg::kind_t kind;

  // Scroll and wrap to the map size
  assign wide  = cfg.map_size[0];
  assign tall  = cfg.map_size[1];
  assign sum_x = 9'(pixel_x) + cfg.scroll_x;
  assign sum_y = 9'(pixel_y) + cfg.scroll_y;
  assign px    = {sum_x[8] & wide, sum_x[7:0]};
  assign py    = {sum_y[8] & tall, sum_y[7:0]};

  // Pick the 32x32 sub-screen and form the map halfword address
  assign block_off = {1'b0, px[8]} + (py[8] ? (wide ? 2'd2 : 2'd1) : 2'd0);
  assign map_blk   = 6'(cfg.map_base) + 6'(block_off);
  assign map_half  = {map_blk, py[7:3], px[7:3]};
  assign map_oob   = map_half >= 16'(ttbp_pkg::VIDEO_HALFWORDS);

  // Range checks
  assign on_screen  = (10'(pixel_x) < 10'(ttbp_pkg::SCREEN_COLUMNS)) &&
                      (10'(pixel_y) < 10'(ttbp_pkg::SCREEN_ROWS));
  assign video_ok   = 16'(write_addr) < 16'(ttbp_pkg::VIDEO_HALFWORDS);
  assign palette_ok = 16'(write_addr) < 16'(ttbp_pkg::PAL_DEPTH);

  // Classify the op; drop items that leave no trace
  always_comb begin
    unique case (op)
      ttbp_pkg::OP_VIDEO_WRITE: begin
        kind = ttbp_pkg::KIND_VIDEO;
        keep = video_ok;
      end
      ttbp_pkg::OP_PALETTE_WRITE: begin
        kind = ttbp_pkg::KIND_PALETTE;
        keep = palette_ok;
      end
      ttbp_pkg::OP_FETCH: begin
        kind = ttbp_pkg::KIND_FETCH;
        keep = on_screen;
      end
      default: begin
        kind = ttbp_pkg::KIND_FETCH;
        keep = 1'b0;
      end
    endcase
  end

  assign req_stall = qstat.full;
  assign push      = req_valid && !req_stall && keep;

  always_comb begin
    push_item.kind    = kind;
    push_item.addr    = (kind == ttbp_pkg::KIND_FETCH) ? map_half[14:0] : write_addr;
    push_item.data    = write_data;
    push_item.tpx     = px[2:0];
    push_item.tpy     = py[2:0];
    push_item.map_oob = map_oob;
  end

endmodule

FILE: sv/ttbp_queue.sv
`include "text_tile_background_pixel_defines.svh"

module ttbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ttbp_pkg::item_t  push_item,
  input  logic             pop,
  output ttbp_pkg::item_t  head,
  output ttbp_pkg::qstat_t qstat
);

  ttbp_pkg::item_t entries [ttbp_pkg::QUEUE_DEPTH];
  logic [ttbp_pkg::QPTR_W-1:0] wr_ptr;
  logic [ttbp_pkg::QPTR_W-1:0] rd_ptr;
  logic [ttbp_pkg::QCNT_W-1:0] count;
  logic full;
  logic empty;

  assign full  = count == ttbp_pkg::QCNT_W'(ttbp_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign qstat = '{full: full, empty: empty};
  assign head  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ttbp_pkg::QPTR_W'(ttbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ttbp_pkg::QPTR_W'(ttbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TTBP_ASSERT_NOW(q_count_bound, 1'b1, count <= ttbp_pkg::QCNT_W'(ttbp_pkg::QUEUE_DEPTH), "queue occupancy above depth")
  `TTBP_ASSERT_NOW(q_pop_nonempty, pop, !empty, "pop from empty queue")
  `TTBP_ASSERT_NEXT(q_push_grows, push && !pop, count == $past(count) + 1'b1, "push lost")

endmodule

FILE: sv/ttbp_back.sv
`include "text_tile_background_pixel_defines.svh"

module ttbp_back (
  input  logic             clk,
  input  logic             rst,
  input  ttbp_pkg::cfg_t   cfg,
  input  ttbp_pkg::item_t  head,
  input  ttbp_pkg::qstat_t qstat,
  output logic             pop,
  input  logic             res_stall,
  output logic             res_valid,
  output logic [31:0]      argb,
  output logic             transparent
);

  logic [15:0] vram [ttbp_pkg::VIDEO_HALFWORDS];
  logic [14:0] pal  [ttbp_pkg::PAL_DEPTH];

  logic en;

  // Stage 1: map entry read
  logic            s1_valid;
  ttbp_pkg::kind_t s1_kind;
  logic [2:0]      s1_tpx;
  logic [2:0]      s1_tpy;
  logic            s1_map_oob;
  logic [7:0]      s1_pal_addr;
  logic [14:0]     s1_pal_data;
  logic [15:0]     map_q;

  logic [15:0] entry;
  logic [9:0]  tile;
  logic [3:0]  bank;
  logic [2:0]  tpx;
  logic [2:0]  tpy;
  logic [15:0] tile_off;
  logic [ttbp_pkg::BYTE_ADDR_W-1:0] tile_byte;
  logic        tile_oob;
  logic [ttbp_pkg::VADDR_W-1:0] tile_half;

  // Stage 2: tile byte read
  logic            s2_valid;
  ttbp_pkg::kind_t s2_kind;
  logic            s2_tile_oob;
  logic            s2_byte_sel;
  logic            s2_nib_sel;
  logic [3:0]      s2_bank;
  logic [7:0]      s2_pal_addr;
  logic [14:0]     s2_pal_data;
  logic [15:0]     tile_q;

  logic [7:0] tbyte;
  logic [3:0] nib;
  logic       idx_zero;
  logic [7:0] pal_rd;

  // Stage 3: palette read, result register
  logic        s3_valid;
  logic        s3_transparent;
  logic [14:0] pal_q;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    expand5 = {c, c[4:2]};
  endfunction

  // The whole pipeline moves together unless a result is held
  assign en  = !s3_valid || !res_stall;
  assign pop = en && !qstat.empty;

  // Decode the map entry and form the tile byte address
  assign entry     = s1_map_oob ? 16'h0000 : map_q;
  assign tile      = entry[9:0];
  assign bank      = entry[15:12];
  assign tpx       = s1_tpx ^ {3{entry[10]}};
  assign tpy       = s1_tpy ^ {3{entry[11]}};
  assign tile_off  = cfg.wide_colour ? {tile, tpy, tpx} : {1'b0, tile, tpy, tpx[2:1]};
  assign tile_byte = {1'b0, cfg.char_base, 14'b0} + ttbp_pkg::BYTE_ADDR_W'(tile_off);
  assign tile_oob  = tile_byte >= ttbp_pkg::BYTE_ADDR_W'(ttbp_pkg::VIDEO_BYTES);
  assign tile_half = tile_byte[ttbp_pkg::VADDR_W:1];

  // Pick byte and nibble, form the palette index
  assign tbyte    = s2_tile_oob ? 8'h00 : (s2_byte_sel ? tile_q[15:8] : tile_q[7:0]);
  assign nib      = s2_nib_sel ? tbyte[7:4] : tbyte[3:0];
  assign idx_zero = cfg.wide_colour ? (tbyte == 8'h00) : (nib == 4'h0);
  assign pal_rd   = cfg.wide_colour ? tbyte : {s2_bank, nib};

  // Video memory: write and map read for the entering item, tile read for the older one
  always_ff @(posedge clk) begin
    if (en) begin
      if (pop && head.kind == ttbp_pkg::KIND_VIDEO) begin
        vram[head.addr[ttbp_pkg::VADDR_W-1:0]] <= head.data;
      end
      map_q  <= vram[head.addr[ttbp_pkg::VADDR_W-1:0]];
      tile_q <= vram[tile_half];
    end
  end

  // Palette: writes and reads from the same stage keep item order
  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_valid && s2_kind == ttbp_pkg::KIND_PALETTE) begin
        pal[s2_pal_addr] <= s2_pal_data;
      end
      pal_q <= pal[pal_rd];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_kind == ttbp_pkg::KIND_FETCH;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind        <= head.kind;
      s1_tpx         <= head.tpx;
      s1_tpy         <= head.tpy;
      s1_map_oob     <= head.map_oob;
      s1_pal_addr    <= head.addr[7:0];
      s1_pal_data    <= head.data[14:0];
      s2_kind        <= s1_kind;
      s2_tile_oob    <= tile_oob;
      s2_byte_sel    <= tile_byte[0];
      s2_nib_sel     <= tpx[0];
      s2_bank        <= bank;
      s2_pal_addr    <= s1_pal_addr;
      s2_pal_data    <= s1_pal_data;
      s3_transparent <= idx_zero;
    end
  end

  // Expand BGR555 to ARGB8888
  assign res_valid   = s3_valid;
  assign transparent = s3_transparent;
  assign argb        = s3_transparent ? 32'h0000_0000 :
                       {8'hFF, expand5(pal_q[4:0]), expand5(pal_q[9:5]), expand5(pal_q[14:10])};

  `TTBP_ASSERT_NEXT(b_fetch_reaches_out, en && s2_valid && s2_kind == ttbp_pkg::KIND_FETCH, res_valid, "fetch lost before result")
  `TTBP_ASSERT_NEXT(b_frozen_on_stall, !en, $stable(s1_valid) && $stable(s2_valid), "pipeline moved while held")

endmodule

FILE: sv/text_tile_background_pixel.sv
// Tiled text-background pixel fetch for one layer. Items carry an op: write a
// video-memory halfword, write a BGR555 palette entry, or fetch the pixel at a
// screen position, which returns one ARGB8888 result (zero with transparent
// set when the colour index is zero); writes, unused ops and off-screen
// fetches give no result. One item is accepted per clock while req_stall is
// low, a rate set by the video memory's two read ports (map entry, then tile
// byte, in successive stages) and the palette's single read port, each used
// once per item. A four-entry queue behind the input lets requests keep
// flowing while a result is held by res_stall. Both memories power up
// undefined and need no clearing. Configuration must be written by the user
// through cfg_write/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this.
module text_tile_background_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [14:0] write_addr,
  input  logic [15:0] write_data,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [31:0] argb,
  output logic        transparent
);

  ttbp_pkg::cfg_t   cfg;
  ttbp_pkg::qstat_t qstat;
  ttbp_pkg::item_t  push_item;
  ttbp_pkg::item_t  head;
  logic             push;
  logic             pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ttbp_pkg::CFG_CHAR_BASE:   cfg.char_base   <= cfg_data[1:0];
        ttbp_pkg::CFG_MAP_BASE:    cfg.map_base    <= cfg_data[4:0];
        ttbp_pkg::CFG_WIDE_COLOUR: cfg.wide_colour <= cfg_data[0];
        ttbp_pkg::CFG_MAP_SIZE:    cfg.map_size    <= cfg_data[1:0];
        ttbp_pkg::CFG_SCROLL_X:    cfg.scroll_x    <= cfg_data;
        ttbp_pkg::CFG_SCROLL_Y:    cfg.scroll_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  ttbp_front u_front (
    .cfg        (cfg),
    .req_valid  (req_valid),
    .op         (op),
    .write_addr (write_addr),
    .write_data (write_data),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .qstat      (qstat),
    .req_stall  (req_stall),
    .push       (push),
    .push_item  (push_item)
  );

  ttbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ttbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .res_stall   (res_stall),
    .res_valid   (res_valid),
    .argb        (argb),
    .transparent (transparent)
  );

endmodule
